// ----- design/tprq_pkg.sv -----
// shared types and codes for the timestamp priority request queue
`timescale 1ns / 1ps

package tprq_pkg;

  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  localparam int unsigned CAP_RESET = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] request_ts;
    logic [5:0]  request_src;
    logic [7:0]  request_type;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [4:0]  entry_count;
    logic        head_valid;
    logic [30:0] head_ts;
    logic [5:0]  head_src;
    logic [7:0]  head_type;
  } out_t;

  typedef struct packed {
    logic [30:0] ts;
    logic [5:0]  src;
    logic [7:0]  payload;
  } entry_t;

  typedef struct packed {
    logic   drop;
    logic   ins;
    entry_t key;
  } ctl_t;

endpackage

// ----- design/timestamp_priority_request_queue_top.sv -----
// timestamp priority request queue: sorted chain of cells with sequencer
// the result is registered in the report state; an enqueue that inserts passes through the insert state first
// input is taken only in idle, so each item reaches its result before the next is taken; a stalled result holds input
// drop and insert each act across all cells in parallel
// reset clears the entry count and result valid, capacity returns to 16
`timescale 1ns / 1ps

module timestamp_priority_request_queue_top
  import tprq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [4:0]    cap_q;
  logic          status_q, status_d;
  entry_t        req_q, req_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  ctl_t            ctl;
  entry_t          in_key;
  entry_t          entry_w [DEPTH];
  logic [DEPTH-1:0] before_w, hit_w, older_w, occ_w;
  logic            accept, found, older, full;
  logic [CW+4:0]   cnt_ext, cap_ext;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_key = '{ts: in_data_i.request_ts, src: in_data_i.request_src,
                    payload: in_data_i.request_type};

  assign found   = hit_w[DEPTH-1];
  assign older   = |older_w;
  assign cnt_ext = {5'd0, count_q};
  assign cap_ext = {{CW{1'b0}}, cap_q};
  assign full    = (cnt_ext >= cap_ext) || (count_q >= CW'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left, right;
    logic   before_in, hit_in;
    assign occ_w[i] = (count_q > CW'(i));
    if (i == 0) begin : g_first
      assign left      = ctl.key;
      assign before_in = 1'b1;
      assign hit_in    = 1'b0;
    end else begin : g_mid
      assign left      = entry_w[i-1];
      assign before_in = before_w[i-1];
      assign hit_in    = hit_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = entry_w[i];
    end else begin : g_inner
      assign right = entry_w[i+1];
    end
    tprq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ_w[i]),
      .left_i      (left),
      .right_i     (right),
      .before_in_i (before_in),
      .hit_in_i    (hit_in),
      .entry_o     (entry_w[i]),
      .before_o    (before_w[i]),
      .hit_o       (hit_w[i]),
      .older_o     (older_w[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    req_d       = req_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ctl.drop    = 1'b0;
    ctl.ins     = 1'b0;
    ctl.key     = (state_q == ST_IDLE) ? in_key : req_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d    = in_key;
          status_d = 1'b0;
          state_d  = ST_REPORT;
          case (in_data_i.kind)
            KIND_ENQUEUE: begin
              if (found) begin
                if (older) begin
                  ctl.drop = 1'b1;
                  count_d  = count_q - CW'(1);
                  state_d  = ST_INSERT;
                end
              end else if (full) begin
                status_d = 1'b1;
              end else begin
                state_d = ST_INSERT;
              end
            end
            KIND_REMOVE: begin
              ctl.drop = 1'b1;
              if (found) begin
                count_d = count_q - CW'(1);
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INSERT: begin
        ctl.ins = 1'b1;
        count_d = count_q + CW'(1);
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.entry_count = cnt_ext[4:0];
          out_d.head_valid  = (count_q != '0);
          out_d.head_ts     = (count_q != '0) ? entry_w[0].ts : '0;
          out_d.head_src    = (count_q != '0) ? entry_w[0].src : '0;
          out_d.head_type   = (count_q != '0) ? entry_w[0].payload : '0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= 5'(CAP_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    req_q    <= req_d;
    out_q    <= out_d;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_then_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INSERT |=> state_q == ST_REPORT)
    else $error("insert not followed by report");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.kind == KIND_CLEAR) |=> count_q == '0)
    else $error("clear left entries");

  a_reject_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPORT && status_q) |-> $stable(count_q))
    else $error("rejected enqueue changed count");
`endif

endmodule

// ----- design/tprq_cell.sv -----
// one queue slot: holds an entry, shifts toward head on drop, away on insert
`timescale 1ns / 1ps

module tprq_cell
  import tprq_pkg::*;
(
  input  logic   clk_i,
  input  ctl_t   ctl_i,
  input  logic   occ_i,
  input  entry_t left_i,
  input  entry_t right_i,
  input  logic   before_in_i,
  input  logic   hit_in_i,
  output entry_t entry_o,
  output logic   before_o,
  output logic   hit_o,
  output logic   older_o
);

  entry_t entry_q, entry_d;
  logic   match;

  assign match    = occ_i && (entry_q.src == ctl_i.key.src);
  assign hit_o    = hit_in_i | match;
  assign older_o  = match && (ctl_i.key.ts < entry_q.ts);
  assign before_o = occ_i && ((entry_q.ts < ctl_i.key.ts) ||
                    ((entry_q.ts == ctl_i.key.ts) && (entry_q.src < ctl_i.key.src)));
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.drop && hit_o) begin
      entry_d = right_i;
    end else if (ctl_i.ins && !before_o) begin
      entry_d = before_in_i ? ctl_i.key : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- tb/timestamp_priority_request_queue_top_tb.sv -----
// testbench for the timestamp priority request queue: directed table, then random phases
`timescale 1ns / 1ps

module timestamp_priority_request_queue_top_tb;
  import tprq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [30:0] TS_MAX = 31'h7fff_ffff;
  localparam int unsigned ITEMS_PER_PHASE = 140;

  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_e;

  typedef struct {
    bit         is_cfg;
    logic [4:0] cap;
    in_t        req;
    bit         typed;
    out_t       result;
  } plan_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i;

  entry_t      held_entries[$];
  logic [4:0]  capacity_shadow = 5'(CAP_RESET);
  out_t        expected_results[$];
  int unsigned mismatch_count = 0;

  bit          typed_valid;
  out_t        typed_result;
  out_t        predicted;
  ready_mode_e ready_mode = READY_ALWAYS;
  int unsigned ready_cycle = 0;

  timestamp_priority_request_queue_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void insert_in_order(entry_t e);
    int unsigned pos;
    pos = 0;
    while (pos < held_entries.size() &&
           !(e.ts < held_entries[pos].ts ||
             (e.ts == held_entries[pos].ts && e.src < held_entries[pos].src)))
      pos++;
    held_entries.insert(pos, e);
  endfunction

  function automatic out_t apply_request(in_t req);
    out_t        r;
    entry_t      e;
    int unsigned lim;
    int          pos;
    r = '0;
    e.ts = req.request_ts;
    e.src = req.request_src;
    e.payload = req.request_type;
    lim = (capacity_shadow < DEPTH) ? capacity_shadow : DEPTH;
    pos = -1;
    case (req.kind)
      KIND_ENQUEUE: begin
        for (int i = 0; i < held_entries.size(); i++) begin
          if (pos < 0 && held_entries[i].src == e.src) pos = i;
        end
        if (pos >= 0) begin
          if (e.ts < held_entries[pos].ts) begin
            held_entries.delete(pos);
            insert_in_order(e);
          end
        end else if (held_entries.size() >= lim) begin
          r.status = 1'b1;
        end else begin
          insert_in_order(e);
        end
      end
      KIND_REMOVE: begin
        for (int i = held_entries.size() - 1; i >= 0; i--) begin
          if (held_entries[i].src == e.src) held_entries.delete(i);
        end
      end
      KIND_CLEAR: begin
        held_entries.delete();
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(held_entries.size());
    if (held_entries.size() > 0) begin
      r.head_valid = 1'b1;
      r.head_ts = held_entries[0].ts;
      r.head_src = held_entries[0].src;
      r.head_type = held_entries[0].payload;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // transfer monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) capacity_shadow = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        predicted = apply_request(in_data_i);
        expected_results.push_back(typed_valid ? typed_result : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
          mismatch_count++;
        end else begin
          predicted = expected_results.pop_front();
          check_field("status", 32'(predicted.status), 32'(out_data_o.status));
          check_field("entry_count", 32'(predicted.entry_count), 32'(out_data_o.entry_count));
          check_field("head_valid", 32'(predicted.head_valid), 32'(out_data_o.head_valid));
          check_field("head_ts", 32'(predicted.head_ts), 32'(out_data_o.head_ts));
          check_field("head_src", 32'(predicted.head_src), 32'(out_data_o.head_src));
          check_field("head_type", 32'(predicted.head_type), 32'(out_data_o.head_type));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 256 == 255) ready_mode <= ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready_i <= ($urandom_range(0, 9) == 0);
      default:      out_ready_i <= (ready_cycle % 8 < 5);
    endcase
  end

  task automatic push_request(input in_t req, input bit typed, input out_t result);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    typed_valid <= typed;
    typed_result <= result;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_t random_request(int unsigned remove_pct);
    in_t         req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < remove_pct) req.kind = KIND_REMOVE;
    else if (pick < remove_pct + 2) req.kind = KIND_CLEAR;
    else if (pick < remove_pct + 4) req.kind = KIND_UNUSED;
    else req.kind = KIND_ENQUEUE;
    pick = $urandom_range(0, 9);
    if (pick < 3) req.request_ts = 31'($urandom_range(0, 15));
    else if (pick == 3) req.request_ts = $urandom_range(0, 1) ? TS_MAX : 31'd0;
    else req.request_ts = 31'($urandom());
    req.request_src = ($urandom_range(0, 4) < 2) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 23));
    req.request_type = 8'($urandom_range(0, 255));
    return req;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] k, logic [30:0] ts, logic [5:0] src,
                                         logic [7:0] ty);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.cap = '0;
    row.req = '{kind: k, request_ts: ts, request_src: src, request_type: ty};
    row.typed = 1'b0;
    row.result = '0;
    return row;
  endfunction

  function automatic plan_row_t checked_row(logic [1:0] k, logic [30:0] ts, logic [5:0] src,
                                            logic [7:0] ty, logic st, logic [4:0] cnt,
                                            logic hv, logic [30:0] hts, logic [5:0] hsrc,
                                            logic [7:0] hty);
    plan_row_t row;
    row = item_row(k, ts, src, ty);
    row.typed = 1'b1;
    row.result = '{status: st, entry_count: cnt, head_valid: hv, head_ts: hts,
                   head_src: hsrc, head_type: hty};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [4:0] cap);
    plan_row_t row;
    row = item_row(KIND_CLEAR, '0, '0, '0);
    row.is_cfg = 1'b1;
    row.cap = cap;
    return row;
  endfunction

  initial begin
    plan_row_t   plan[$];
    logic [4:0]  phase_caps[$];
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    int unsigned remove_pct;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    typed_valid = 1'b0;
    typed_result = '0;

    // empty queue, unused kind, extremes, ties, duplicates
    plan.push_back(checked_row(KIND_CLEAR, 31'd0, 6'd0, 8'd0, 1'b0, 5'd0, 1'b0,
                               31'd0, 6'd0, 8'd0));
    plan.push_back(checked_row(KIND_REMOVE, 31'd0, 6'd63, 8'd0, 1'b0, 5'd0, 1'b0,
                               31'd0, 6'd0, 8'd0));
    plan.push_back(checked_row(KIND_UNUSED, TS_MAX, 6'd63, 8'd255, 1'b0, 5'd0, 1'b0,
                               31'd0, 6'd0, 8'd0));
    plan.push_back(checked_row(KIND_ENQUEUE, TS_MAX, 6'd63, 8'd255,
                               1'b0, 5'd1, 1'b1, TS_MAX, 6'd63, 8'd255));
    plan.push_back(checked_row(KIND_ENQUEUE, 31'd0, 6'd0, 8'd0, 1'b0, 5'd2, 1'b1,
                               31'd0, 6'd0, 8'd0));
    plan.push_back(item_row(KIND_ENQUEUE, 31'd0, 6'd5, 8'ha5));
    plan.push_back(item_row(KIND_ENQUEUE, 31'd0, 6'd5, 8'h5a));
    plan.push_back(item_row(KIND_ENQUEUE, 31'd100, 6'd63, 8'h11));
    plan.push_back(item_row(KIND_ENQUEUE, 31'd200, 6'd63, 8'h22));
    plan.push_back(item_row(KIND_REMOVE, 31'd0, 6'd0, 8'd0));
    plan.push_back(item_row(KIND_REMOVE, 31'd0, 6'd10, 8'd0));
    plan.push_back(item_row(KIND_UNUSED, 31'd0, 6'd5, 8'd0));
    plan.push_back(checked_row(KIND_CLEAR, 31'd0, 6'd0, 8'd0, 1'b0, 5'd0, 1'b0,
                               31'd0, 6'd0, 8'd0));
    // zero capacity rejects everything new
    plan.push_back(cfg_row(5'd0));
    plan.push_back(checked_row(KIND_ENQUEUE, 31'd7, 6'd1, 8'd1, 1'b1, 5'd0, 1'b0,
                               31'd0, 6'd0, 8'd0));
    plan.push_back(cfg_row(5'd2));
    plan.push_back(checked_row(KIND_ENQUEUE, 31'd50, 6'd2, 8'd2, 1'b0, 5'd1, 1'b1,
                               31'd50, 6'd2, 8'd2));
    plan.push_back(item_row(KIND_ENQUEUE, 31'd40, 6'd3, 8'd3));
    plan.push_back(checked_row(KIND_ENQUEUE, 31'd10, 6'd4, 8'd4, 1'b1, 5'd2, 1'b1,
                               31'd40, 6'd3, 8'd3));
    plan.push_back(item_row(KIND_ENQUEUE, 31'd30, 6'd2, 8'd9));
    // capacity below count: new sources rejected, replacements still go in
    plan.push_back(cfg_row(5'd1));
    plan.push_back(checked_row(KIND_ENQUEUE, 31'd5, 6'd6, 8'd6, 1'b1, 5'd2, 1'b1,
                               31'd30, 6'd2, 8'd9));
    plan.push_back(item_row(KIND_ENQUEUE, 31'd1, 6'd3, 8'd3));
    plan.push_back(item_row(KIND_REMOVE, 31'd0, 6'd3, 8'd0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_capacity(plan[i].cap);
      else push_request(plan[i].req, plan[i].typed, plan[i].result);
    end

    phase_caps = '{5'd31, 5'd2, 5'd16, 5'd0, 5'd8, 5'd1, 5'd17, 5'd5, 5'd15};
    phase_caps.push_back(5'($urandom_range(0, 31)));
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      remove_pct = $urandom_range(5, 30);
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > left) burst = left;
        repeat (burst) push_request(random_request(remove_pct), 1'b0, '0);
        left -= burst;
        if ($urandom_range(0, 29) == 0) begin
          drain_results();
        end else begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("timestamp_priority_request_queue_top test passed");
    end else begin
      $display("timestamp_priority_request_queue_top test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timestamp_priority_request_queue_top test failed");
    $finish;
  end

endmodule

// ----- files.f -----
design/tprq_pkg.sv
design/tprq_cell.sv
design/timestamp_priority_request_queue_top.sv
tb/timestamp_priority_request_queue_top_tb.sv
